[rtl/d8_flow_direction_core_assert.svh]
// Assertion macros shared by the verification files of the D8 flow direction core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef D8_FLOW_DIRECTION_CORE_ASSERT_SVH
`define D8_FLOW_DIRECTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define D8FD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define D8FD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/d8fd_pkg.sv]
// Package for the D8 flow direction core: constants, register codes and shared types.
// No dependencies; used by the output queue and the top level.
package d8fd_pkg;

	localparam int MAX_ROW_LENGTH_DEF = 4098;
	localparam int ELEVATION_BITS_DEF = 32;

	localparam int ELEV_FIELD_W = 32;
	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam int CODE_W       = 8;
	localparam int NB_COUNT     = 8;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd4098;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [15:0] DIAG_Q16 = 16'd46341;

	localparam int FIFO_DEPTH = 8;

	// Window slot of each neighbor in the order E, NE, N, NW, W, SW, S, SE.
	localparam logic [3:0] NB_POS [NB_COUNT] = '{
		4'd5, 4'd2, 4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8
	};
	localparam logic [3:0] CENTER_POS = 4'd4;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} result_t;

endpackage

[rtl/d8fd_out_fifo.sv]
// Output queue of the D8 flow direction core, holding finished results until taken.
// Depends on d8fd_pkg for the result type and the queue depth.
module d8fd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  d8fd_pkg::result_t push_data,
	input  logic              pop,
	output logic              out_valid,
	output d8fd_pkg::result_t out_data
);
	import d8fd_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	result_t            slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/d8_flow_direction_core.sv]
// D8 flow direction core: streams a padded elevation raster and emits one-hot D8 codes.
// Depends on d8fd_pkg and instantiates d8fd_out_fifo.
//
// Samples enter in raster order, ghost border included. The two previous rows live in one
// row memory with a single read port and a single write port: each sample reads its
// column at acceptance and writes it back in the next cycle, so columns never collide and
// the sustained rate is one sample per clock while s_tready is high. A result then passes
// window, drop, scaling and compare registers, a combinational final compare and the
// output queue. Up to eight results may be pending, counting those still in the pipeline;
// s_tready falls while eight are in flight or waiting at the output. No clearing pass
// follows reset: a fill count marks which columns hold data, and columns beyond it read
// as zero elevation with data present. Writing either register restarts the frame at
// row 0, column 0 and is meant for an idle block.
module d8_flow_direction_core #(
	parameter int MAX_ROW_LENGTH = d8fd_pkg::MAX_ROW_LENGTH_DEF,
	parameter int ELEVATION_BITS = d8fd_pkg::ELEVATION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata [31:0]: elevation
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// s_tuser [0]: no_data
	input  logic        s_tuser,
	// m_tdata [7:0]: direction_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import d8fd_pkg::*;

	localparam int EB     = ELEVATION_BITS;
	localparam int SW     = EB + 1;
	localparam int DW     = EB + 1;
	localparam int PW     = DW + 16;
	localparam int AW     = $clog2(MAX_ROW_LENGTH);
	localparam int CNT_W  = $clog2(MAX_ROW_LENGTH + 1);
	localparam int EXT_W  = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;
	localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CNT_W-1:0]        col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [CNT_W-1:0]        fill_q;
	logic [PEND_W-1:0]       pending_q;

	logic                    cfg_wr;
	logic                    accept;
	logic                    emit_in;
	logic                    last_in;
	logic [EXT_W-1:0]        width_ext;
	logic [EXT_W-1:0]        eff_w_ext;
	logic [CNT_W-1:0]        eff_w;
	logic [HEIGHT_REG_W-1:0] eff_h;
	logic [63:0]             elev_wide;
	logic [SW-1:0]           cur_in;

	logic [2*SW-1:0]         row_mem [MAX_ROW_LENGTH];
	logic [2*SW-1:0]         rd_q;

	logic                    v_s1;
	logic                    emit_s1;
	logic                    last_s1;
	logic                    hit_s1;
	logic [AW-1:0]           addr_s1;
	logic [SW-1:0]           cur_s1;
	logic [SW-1:0]           up_s1;
	logic [SW-1:0]           mid_s1;

	logic [SW-1:0]           win_q [9];
	logic                    v_s2;
	logic                    last_s2;

	logic [DW-1:0]           drop_s3 [NB_COUNT];
	logic                    v_s3;
	logic                    last_s3;

	logic [PW-1:0]           scaled_s4 [NB_COUNT];
	logic                    v_s4;
	logic                    last_s4;

	logic [PW-1:0]           best_s5 [4];
	logic [2:0]              idx_s5 [4];
	logic                    v_s5;
	logic                    last_s5;

	logic [PW-1:0]           lvl_val [2];
	logic [2:0]              lvl_idx [2];
	logic [PW-1:0]           fin_val;
	logic [2:0]              fin_idx;
	result_t                 push_res;
	result_t                 out_res;
	logic                    pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {16'b0, height_q} : {19'b0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HEIGHT) begin
				height_q <= pwdata[HEIGHT_REG_W-1:0];
			end else begin
				width_q <= pwdata[WIDTH_REG_W-1:0];
			end
		end
	end

	always_comb begin
		width_ext = EXT_W'(width_q);
		if (width_ext < EXT_W'(3)) begin
			eff_w_ext = EXT_W'(3);
		end else if (width_ext > EXT_W'(MAX_ROW_LENGTH)) begin
			eff_w_ext = EXT_W'(MAX_ROW_LENGTH);
		end else begin
			eff_w_ext = width_ext;
		end
		eff_w = eff_w_ext[CNT_W-1:0];
		eff_h = (height_q < HEIGHT_REG_W'(3)) ? HEIGHT_REG_W'(3) : height_q;
	end

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (pending_q < PEND_W'(FIFO_DEPTH));
	assign elev_wide = {32'b0, s_tdata};
	assign cur_in    = {s_tuser, elev_wide[EB-1:0]};
	assign emit_in   = (col_q >= CNT_W'(2)) && (row_q >= HEIGHT_REG_W'(2));
	assign last_in   = (row_q == eff_h - 1'b1) && (col_q == eff_w - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q >= fill_q) begin
				fill_q <= col_q + 1'b1;
			end
			if (({1'b0, col_q} + 1'b1) >= {1'b0, eff_w}) begin
				col_q <= '0;
				if (({1'b0, row_q} + 1'b1) >= {1'b0, eff_h}) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Row memory entry: upper row in the high half, middle row in the low half.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= row_mem[col_q[AW-1:0]];
		end
		if (v_s1) begin
			row_mem[addr_s1] <= {mid_s1, cur_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1  <= cur_in;
			addr_s1 <= col_q[AW-1:0];
			hit_s1  <= (col_q < fill_q);
			last_s1 <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1    <= accept;
			emit_s1 <= accept && emit_in;
		end
	end

	assign up_s1  = hit_s1 ? rd_q[2*SW-1:SW] : '0;
	assign mid_s1 = hit_s1 ? rd_q[SW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_s1;
			win_q[5] <= mid_s1;
			win_q[8] <= cur_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		last_s5 <= last_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [SW-1:0] ctr;
		logic [SW-1:0] nb;
		ctr = win_q[CENTER_POS];
		for (int k = 0; k < NB_COUNT; k++) begin
			nb = win_q[NB_POS[k]];
			if (!ctr[SW-1] && !nb[SW-1] && ($signed(ctr[EB-1:0]) > $signed(nb[EB-1:0]))) begin
				drop_s3[k] <= {ctr[EB-1], ctr[EB-1:0]} - {nb[EB-1], nb[EB-1:0]};
			end else begin
				drop_s3[k] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NB_COUNT; k++) begin
			if (k % 2 == 1) begin
				scaled_s4[k] <= PW'(drop_s3[k]) * PW'(DIAG_Q16);
			end else begin
				scaled_s4[k] <= {drop_s3[k], 16'b0};
			end
		end
	end

	// Ties keep the lower direction index.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (scaled_s4[2*k+1] > scaled_s4[2*k]) begin
				best_s5[k] <= scaled_s4[2*k+1];
				idx_s5[k]  <= 3'(2*k+1);
			end else begin
				best_s5[k] <= scaled_s4[2*k];
				idx_s5[k]  <= 3'(2*k);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (best_s5[2*k+1] > best_s5[2*k]) begin
				lvl_val[k] = best_s5[2*k+1];
				lvl_idx[k] = idx_s5[2*k+1];
			end else begin
				lvl_val[k] = best_s5[2*k];
				lvl_idx[k] = idx_s5[2*k];
			end
		end
		if (lvl_val[1] > lvl_val[0]) begin
			fin_val = lvl_val[1];
			fin_idx = lvl_idx[1];
		end else begin
			fin_val = lvl_val[0];
			fin_idx = lvl_idx[0];
		end
		push_res.code = (fin_val != '0) ? (CODE_W'(1) << fin_idx) : '0;
		push_res.last = last_s5;
	end

	d8fd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s5),
		.push_data (push_res),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_data  (out_res)
	);

	assign pop     = m_tvalid && m_tready;
	assign m_tdata = out_res.code;
	assign m_tlast = out_res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			if ((accept && emit_in) && !pop) begin
				pending_q <= pending_q + 1'b1;
			end else if (pop && !(accept && emit_in)) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

endmodule

[rtl/d8fd_checker.sv]
// Port-level checker for the D8 flow direction core, bound to its top level.
// Depends on d8_flow_direction_core_assert.svh for the assertion macros.
`include "d8_flow_direction_core_assert.svh"

module d8fd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	logic wr_width;
	logic wr_height;

	assign wr_width  = psel && penable && pwrite && pready && !paddr[2];
	assign wr_height = psel && penable && pwrite && pready && paddr[2];

	`D8FD_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tuser), "stalled input transaction changed")
	`D8FD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output transaction changed")
	`D8FD_ASSERT_NOW(a_code_onehot, m_tvalid, $onehot0(m_tdata), "direction code has more than one bit set")
	`D8FD_ASSERT_NOW(a_width_readback, $past(wr_width) && !paddr[2], prdata == {19'b0, $past(pwdata[12:0])}, "width register does not read back the written value")
	`D8FD_ASSERT_NOW(a_height_readback, $past(wr_height) && paddr[2], prdata == {16'b0, $past(pwdata[15:0])}, "height register does not read back the written value")

endmodule

bind d8_flow_direction_core d8fd_checker u_checker (.*);
